FILE: hdl/tbp_pkg.sv
package tbp_pkg;

    // field widths
    localparam int FUNC_W     = 2;
    localparam int TIME_W     = 48;
    localparam int BYTES_W    = 16;
    localparam int TOK_W      = 32;
    localparam int RATE_CFG_W = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // parameter defaults
    localparam int TICK_NS_DEF  = 1000;
    localparam int KB_BYTES_DEF = 1000;

    // function selector codes
    localparam logic [FUNC_W-1:0] FUNC_REFILL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAKE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST = 2'd1;

    localparam logic [TOK_W-1:0] BURST_RESET = 32'd65535;

    // 1e6 = 2^6 * 15625, 8000 = 2^6 * 125
    localparam int NS_MS_SHIFT = 6;
    localparam int NS_MS_ODD   = 15625;
    localparam int RATE_SHIFT  = 6;
    localparam int RATE_ODD    = 125;
    // byte rate per ms, wide enough for 1024-byte kilobytes at the top rate
    localparam int RATE_W      = 25;

    localparam int SLOP_NS = 50000;

    // interval in ms, capped at 2^32
    localparam int              MS_W   = 33;
    localparam logic [MS_W-1:0] MS_CAP = 33'h1_0000_0000;

    localparam int OFIFO_DEPTH = 32;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BYTES_W-1:0] want;
        logic               upd;
    } t_item;

    typedef struct packed {
        logic               granted;
        logic [TOK_W-1:0]   tokens_left;
    } t_result;

endpackage

FILE: hdl/tbp_div.sv
module tbp_div #(
    parameter int IW        = 48,
    parameter int SW        = 1,
    parameter int DIV_SHIFT = 6,
    parameter int DIV_ODD   = 15625
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    input  logic [IW-1:0]                                 i_x,
    input  logic [SW-1:0]                                 i_side,
    output logic                                          o_valid,
    output logic [IW-DIV_SHIFT-$clog2(DIV_ODD+1):0]       o_q,
    output logic [$clog2(DIV_ODD+1)+DIV_SHIFT-1:0]        o_r,
    output logic [SW-1:0]                                 o_side
);

    localparam int K  = IW - DIV_SHIFT;
    localparam int OW = $clog2(DIV_ODD + 1);
    localparam int QW = K - OW + 1;
    localparam int RW = OW + 1;
    localparam int KL = K / 2;
    localparam int KH = K - KL;
    localparam longint unsigned RECIP = (64'd1 << K) / DIV_ODD;

    // stage a: split reciprocal product
    logic                 r_a_vld;
    logic [KH+QW-1:0]     r_a_hi;
    logic [KL+QW-1:0]     r_a_lo;
    logic [K-1:0]         r_a_x;
    logic [DIV_SHIFT-1:0] r_a_low;
    logic [SW-1:0]        r_a_side;
    // stage b: quotient estimate
    logic                 r_b_vld;
    logic [QW-1:0]        r_b_q;
    logic [K-1:0]         r_b_x;
    logic [DIV_SHIFT-1:0] r_b_low;
    logic [SW-1:0]        r_b_side;
    // stage c: remainder estimate
    logic                 r_c_vld;
    logic [QW-1:0]        r_c_q;
    logic [RW-1:0]        r_c_rem;
    logic [DIV_SHIFT-1:0] r_c_low;
    logic [SW-1:0]        r_c_side;
    // stage d: corrected
    logic                 r_d_vld;
    logic [QW-1:0]        r_d_q;
    logic [OW-1:0]        r_d_rem;
    logic [DIV_SHIFT-1:0] r_d_low;
    logic [SW-1:0]        r_d_side;

    logic [K-1:0]    xs;
    logic [K+QW-1:0] n_b_sum;
    logic            n_d_fix;

    assign xs      = i_x[IW-1:DIV_SHIFT];
    assign n_b_sum = {r_a_hi, {KL{1'b0}}} + (K+QW)'(r_a_lo);
    assign n_d_fix = r_c_rem >= RW'(DIV_ODD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_hi   <= (KH+QW)'(xs[K-1:KL]) * (KH+QW)'(RECIP);
        r_a_lo   <= (KL+QW)'(xs[KL-1:0]) * (KL+QW)'(RECIP);
        r_a_x    <= xs;
        r_a_low  <= i_x[DIV_SHIFT-1:0];
        r_a_side <= i_side;

        r_b_q    <= n_b_sum[K+QW-1:K];
        r_b_x    <= r_a_x;
        r_b_low  <= r_a_low;
        r_b_side <= r_a_side;

        // estimate is low by at most one, so only the low bits matter
        r_c_rem  <= r_b_x[RW-1:0] - RW'(r_b_q * RW'(DIV_ODD));
        r_c_q    <= r_b_q;
        r_c_low  <= r_b_low;
        r_c_side <= r_b_side;

        r_d_q    <= n_d_fix ? r_c_q + QW'(1) : r_c_q;
        r_d_rem  <= n_d_fix ? OW'(r_c_rem - RW'(DIV_ODD)) : OW'(r_c_rem);
        r_d_low  <= r_c_low;
        r_d_side <= r_c_side;
    end

    assign o_valid = r_d_vld;
    assign o_q     = r_d_q;
    assign o_r     = {r_d_rem, r_d_low};
    assign o_side  = r_d_side;

endmodule

FILE: hdl/tbp_ofifo.sv
module tbp_ofifo #(
    parameter int DEPTH = 32,
    parameter int W     = 33
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wdata,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;
    logic          rd;

    assign o_valid = r_cnt != '0;
    assign o_rdata = r_mem[r_rd_ptr];
    assign rd      = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({i_wr, rd})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

FILE: hdl/token_bucket_policer_core.sv
// single-rate token bucket policer
//
// input channel (i_in_valid / o_in_ready): one beat per item, carrying the
// function (refill at i_now_ticks, take i_packet_bytes, reinitialize).
// output channel (o_out_valid / i_out_ready): exactly one beat per item, in
// order, with o_granted and o_tokens_left after that item.
// config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
// committed rate in kbps, index 1 the burst size; other indexes are dropped.
// write config only while no item is in flight.
//
// one item is taken per cycle while o_in_ready is high. the interval math
// (tick delta to milliseconds) is a fixed-depth pipeline, and only the last
// stage touches the token count, which is what lets items follow back to
// back. results collect in a 32-entry output queue; o_in_ready drops only
// when 32 items are accepted and not yet delivered, so a stalled receiver
// throttles the input after the queue fills and nothing is lost.
// reset (synchronous, active low) empties the pipeline and queue, clears the
// rate, sets burst and tokens to 65535 and forgets the last refill time.
module token_bucket_policer_core
    import tbp_pkg::*;
#(
    parameter int TICK_NS  = TICK_NS_DEF,
    parameter int KB_BYTES = KB_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [TIME_W-1:0]     i_now_ticks,
    input  logic [BYTES_W-1:0]    i_packet_bytes,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_granted,
    output logic [TOK_W-1:0]      o_tokens_left,
    // config writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // widths that follow from the tick length and the kilobyte size
    localparam int TW     = $clog2(TICK_NS + 1);
    localparam int KBW    = $clog2(KB_BYTES + 1);
    localparam int ODD1_W = $clog2(NS_MS_ODD + 1);
    localparam int Q1_W   = TIME_W - NS_MS_SHIFT - ODD1_W + 1;   // whole 1e6-tick blocks
    localparam int R1_W   = ODD1_W + NS_MS_SHIFT;                // leftover ticks
    localparam int PW     = R1_W + TW;                           // leftover in ns
    localparam int Q2_W   = PW - NS_MS_SHIFT - ODD1_W + 1;       // ms from leftover
    localparam int WW     = Q1_W + TW;                           // ms from whole blocks
    localparam int MSW    = ((WW > Q2_W) ? WW : Q2_W) + 1;
    localparam int MSX    = (MSW > MS_W) ? MSW : MS_W;
    localparam int RP_W   = RATE_CFG_W + KBW;
    localparam int ODDR_W = $clog2(RATE_ODD + 1);
    localparam int QR_W   = RP_W - RATE_SHIFT - ODDR_W + 1;
    localparam int PROD_W = RATE_W + TOK_W;
    localparam int SUM_W  = TOK_W + 2;
    localparam int CNT_W  = $clog2(OFIFO_DEPTH + 1);

    typedef struct packed {
        t_item            item;
        logic             ge;
        logic [WW-1:0]    whole;
    } t_mid;

    // config registers
    logic [RATE_CFG_W-1:0] r_kbps;
    logic [TOK_W-1:0]      r_burst;
    // byte rate per ms, recomputed continuously from r_kbps
    logic [RP_W-1:0]       r_rate_x;
    logic [RATE_W-1:0]     r_rate;
    logic [QR_W-1:0]       rate_q;

    // in-flight count for the output queue
    logic [CNT_W-1:0] r_cnt;
    logic             in_acc;
    logic             out_acc;

    // input register
    logic               r_in_vld;
    logic [FUNC_W-1:0]  r_in_func;
    logic [TIME_W-1:0]  r_in_now;
    logic [BYTES_W-1:0] r_in_want;

    // time tracking, kept at the front since it depends on inputs only
    logic [TIME_W-1:0] r_last;
    logic              r_seen;
    logic [TIME_W-1:0] n_d;

    logic              r_s1_vld;
    logic [TIME_W-1:0] r_s1_d;
    t_item             r_s1_item;

    logic              d1_vld;
    logic [Q1_W-1:0]   d1_q;
    logic [R1_W-1:0]   d1_r;
    t_item             d1_item;

    logic              r_s6_vld;
    logic [PW-1:0]     r_s6_part;
    logic [WW-1:0]     r_s6_whole;
    t_item             r_s6_item;

    logic              r_s7_vld;
    logic [PW-1:0]     r_s7_p2;
    t_mid              r_s7_mid;

    logic              d2_vld;
    logic [Q2_W-1:0]   d2_q;
    t_mid              d2_mid;

    logic              r_ms_vld;
    logic [MS_W-1:0]   r_ms;
    t_item             r_ms_item;
    logic [MS_W-1:0]   n_ms;

    logic              r_inc_vld;
    logic [PROD_W-1:0] r_inc_prod;
    logic              r_inc_big;
    t_item             r_inc_item;

    logic              r_cap_vld;
    logic [MS_W-1:0]   r_cap_inc;
    t_item             r_cap_item;

    logic [TOK_W-1:0]  r_tokens;
    logic [TOK_W-1:0]  n_tokens;
    logic              n_granted;
    t_result           n_result;
    t_result           q_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = r_cnt < CNT_W'(OFIFO_DEPTH);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_acc     = o_out_valid & i_out_ready;

    // config write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbps  <= '0;
            r_burst <= BURST_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RATE:  r_kbps  <= i_cfg_data[RATE_CFG_W-1:0];
                CFG_BURST: r_burst <= i_cfg_data[TOK_W-1:0];
                default:   ;
            endcase
        end
    end

    // rate = floor(kbps * KB_BYTES / 8000), settles after a write through r_rate_x, the divider and r_rate
    always_ff @(posedge i_clk) begin
        r_rate_x <= RP_W'(r_kbps) * RP_W'(KB_BYTES);
        r_rate   <= RATE_W'(rate_q);
    end

    tbp_div #(
        .IW        (RP_W),
        .SW        (1),
        .DIV_SHIFT (RATE_SHIFT),
        .DIV_ODD   (RATE_ODD)
    ) u_rate_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (1'b1),
        .i_x     (r_rate_x),
        .i_side  (1'b0),
        .o_valid (),
        .o_q     (rate_q),
        .o_r     (),
        .o_side  ()
    );

    // accepted-not-delivered count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_ms_vld  <= 1'b0;
            r_inc_vld <= 1'b0;
            r_cap_vld <= 1'b0;
        end else begin
            r_in_vld  <= in_acc;
            r_s1_vld  <= r_in_vld;
            r_s6_vld  <= d1_vld;
            r_s7_vld  <= r_s6_vld;
            r_ms_vld  <= d2_vld;
            r_inc_vld <= r_ms_vld;
            r_cap_vld <= r_inc_vld;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_func <= i_func;
            r_in_now  <= i_now_ticks;
            r_in_want <= i_packet_bytes;
        end
    end

    // elapsed ticks, zero when time did not move forward
    assign n_d = (r_in_now > r_last) ? r_in_now - r_last : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_seen <= 1'b0;
        end else if (r_in_vld) begin
            unique case (r_in_func)
                FUNC_REFILL: begin
                    r_last <= r_in_now;
                    r_seen <= 1'b1;
                end
                FUNC_INIT: begin
                    r_last <= '0;
                    r_seen <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_s1_d         <= n_d;
            r_s1_item.func <= r_in_func;
            r_s1_item.want <= r_in_want;
            // first refill after init only records the time
            r_s1_item.upd  <= r_seen && (r_in_func == FUNC_REFILL);
        end
    end

    // ticks split into whole 1e6-tick blocks and leftover ticks
    tbp_div #(
        .IW        (TIME_W),
        .SW        ($bits(t_item)),
        .DIV_SHIFT (NS_MS_SHIFT),
        .DIV_ODD   (NS_MS_ODD)
    ) u_tick_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_vld),
        .i_x     (r_s1_d),
        .i_side  (r_s1_item),
        .o_valid (d1_vld),
        .o_q     (d1_q),
        .o_r     (d1_r),
        .o_side  (d1_item)
    );

    always_ff @(posedge i_clk) begin
        if (d1_vld) begin
            r_s6_part  <= PW'(d1_r) * PW'(TICK_NS);
            r_s6_whole <= WW'(d1_q) * WW'(TICK_NS);
            r_s6_item  <= d1_item;
        end
    end

    // take off the slop from the leftover ns
    always_ff @(posedge i_clk) begin
        if (r_s6_vld) begin
            r_s7_mid.item  <= r_s6_item;
            r_s7_mid.whole <= r_s6_whole;
            r_s7_mid.ge    <= r_s6_part >= PW'(SLOP_NS);
            r_s7_p2        <= (r_s6_part >= PW'(SLOP_NS)) ? r_s6_part - PW'(SLOP_NS) : '0;
        end
    end

    tbp_div #(
        .IW        (PW),
        .SW        ($bits(t_mid)),
        .DIV_SHIFT (NS_MS_SHIFT),
        .DIV_ODD   (NS_MS_ODD)
    ) u_ns_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s7_vld),
        .i_x     (r_s7_p2),
        .i_side  (r_s7_mid),
        .o_valid (d2_vld),
        .o_q     (d2_q),
        .o_r     (),
        .o_side  (d2_mid)
    );

    // interval in ms; slop not covered borrows one whole ms
    always_comb begin
        logic [MSW-1:0] ms_full;
        logic [MSX-1:0] ms_x;
        if (d2_mid.ge) begin
            ms_full = MSW'(d2_mid.whole) + MSW'(d2_q);
        end else if (d2_mid.whole == '0) begin
            ms_full = '0;
        end else begin
            ms_full = MSW'(d2_mid.whole - WW'(1));
        end
        ms_x = MSX'(ms_full);
        n_ms = (ms_x > MSX'(MS_CAP)) ? MS_CAP : MS_W'(ms_x);
    end

    always_ff @(posedge i_clk) begin
        if (d2_vld) begin
            r_ms      <= n_ms;
            r_ms_item <= d2_mid.item;
        end
    end

    // tokens to add = rate * ms; the 2^32 cap case is handled by its flag
    always_ff @(posedge i_clk) begin
        if (r_ms_vld) begin
            r_inc_prod <= PROD_W'(r_rate) * PROD_W'(r_ms[TOK_W-1:0]);
            r_inc_big  <= r_ms[MS_W-1] && (r_rate != '0);
            r_inc_item <= r_ms_item;
        end
    end

    // anything at or above 2^32 fills the bucket anyway
    always_ff @(posedge i_clk) begin
        if (r_inc_vld) begin
            r_cap_inc  <= (r_inc_big || (|r_inc_prod[PROD_W-1:TOK_W]))
                          ? MS_CAP : {1'b0, r_inc_prod[TOK_W-1:0]};
            r_cap_item <= r_inc_item;
        end
    end

    // token update, the only stage that reads the count
    always_comb begin
        logic [SUM_W-1:0] sum;
        sum       = SUM_W'(r_tokens) + SUM_W'(r_cap_inc);
        n_tokens  = r_tokens;
        n_granted = 1'b0;
        case (r_cap_item.func)
            FUNC_REFILL: begin
                if (r_cap_item.upd && (r_tokens < r_burst)) begin
                    n_tokens = (sum > SUM_W'(r_burst)) ? r_burst : sum[TOK_W-1:0];
                end
            end
            FUNC_TAKE: begin
                if (r_tokens >= TOK_W'(r_cap_item.want)) begin
                    n_tokens  = r_tokens - TOK_W'(r_cap_item.want);
                    n_granted = 1'b1;
                end
            end
            FUNC_INIT: begin
                n_tokens = r_burst;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tokens <= BURST_RESET;
        end else if (r_cap_vld) begin
            r_tokens <= n_tokens;
        end
    end

    assign n_result.granted     = n_granted;
    assign n_result.tokens_left = n_tokens;

    tbp_ofifo #(
        .DEPTH (OFIFO_DEPTH),
        .W     ($bits(t_result))
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_cap_vld),
        .i_wdata (n_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_rdata (q_result)
    );

    assign o_granted     = q_result.granted;
    assign o_tokens_left = q_result.tokens_left;

endmodule

FILE: hdl/tbp_chk.sv
module tbp_chk
    import tbp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [FUNC_W-1:0]     i_func,
    input logic [TIME_W-1:0]     i_now_ticks,
    input logic [BYTES_W-1:0]    i_packet_bytes,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_granted,
    input logic [TOK_W-1:0]      o_tokens_left
);

    // reset empties the block and opens the input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output beat or blocked input right after reset");

    // a held output beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_granted) && $stable(o_tokens_left)))
        else $error("output beat changed while stalled");

    // input only throttles when results are waiting
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input blocked with no result pending");

    // the queue was empty just before its first result, so the input was open
    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_ready))
        else $error("output beat appeared with the input queue full");

    // a waiting input beat stays put until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_func) && $stable(i_now_ticks)
             && $stable(i_packet_bytes)))
        else $error("input beat dropped or changed while waiting");

endmodule

bind token_bucket_policer_core tbp_chk u_tbp_chk (.*);

FILE: dv/tbp_policer_check.sv
`timescale 1ns / 100ps

module tbp_policer_check
    import tbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [TIME_W-1:0]     i_now_ticks,
    input  logic [BYTES_W-1:0]    i_packet_bytes,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_granted,
    input  logic [TOK_W-1:0]      i_tokens_left,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    typedef longint unsigned t_u64;

    localparam t_u64 NS_PER_MS = 64'd1000000;

    // shadow of the bucket and its two registers
    logic [RATE_CFG_W-1:0] rate_kbps;
    logic [TOK_W-1:0]      burst;
    logic [TOK_W-1:0]      tokens;
    logic [TIME_W-1:0]     last_ticks;
    logic                  time_known;

    t_result policer_verdicts[$];

    // whole ms since the last refill, less the slop, capped
    function automatic t_u64 refill_interval_ms(input logic [TIME_W-1:0] now);
        t_u64 delta;
        t_u64 ns;
        t_u64 ms;
        if (now <= last_ticks)
            return 0;
        delta = now - last_ticks;
        ns = delta * TICK_NS_DEF;
        if (ns <= SLOP_NS)
            return 0;
        ms = (ns - SLOP_NS) / NS_PER_MS;
        return (ms > t_u64'(MS_CAP)) ? t_u64'(MS_CAP) : ms;
    endfunction

    function automatic t_result police_item(input logic [FUNC_W-1:0] f,
                                            input logic [TIME_W-1:0] now,
                                            input logic [BYTES_W-1:0] want);
        t_result r;
        t_u64    per_ms;
        t_u64    grown;
        r.granted = 1'b0;
        case (f)
            FUNC_REFILL: begin
                if (time_known && tokens < burst) begin
                    per_ms = t_u64'(rate_kbps) * KB_BYTES_DEF / 8 / 1000;
                    grown = t_u64'(tokens) + per_ms * refill_interval_ms(now);
                    tokens = (grown > t_u64'(burst)) ? burst : grown[TOK_W-1:0];
                end
                last_ticks = now;
                time_known = 1'b1;
            end
            FUNC_TAKE: begin
                if (tokens >= want) begin
                    tokens = tokens - want;
                    r.granted = 1'b1;
                end
            end
            FUNC_INIT: begin
                tokens = burst;
                last_ticks = '0;
                time_known = 1'b0;
            end
            default: ;
        endcase
        r.tokens_left = tokens;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            rate_kbps = '0;
            burst = BURST_RESET;
            tokens = BURST_RESET;
            last_ticks = '0;
            time_known = 1'b0;
            policer_verdicts.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RATE:  rate_kbps = i_cfg_data[RATE_CFG_W-1:0];
                    CFG_BURST: burst = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (policer_verdicts.size() == 0) begin
                    $display("[%0t] result beat with nothing outstanding: granted %0d tokens %0d",
                             $time, i_granted, i_tokens_left);
                    o_errors++;
                end else begin
                    due = policer_verdicts.pop_front();
                    if (i_granted !== due.granted) begin
                        $display("[%0t] granted: expected %0d, actual %0d",
                                 $time, due.granted, i_granted);
                        o_errors++;
                    end
                    if (i_tokens_left !== due.tokens_left) begin
                        $display("[%0t] tokens_left: expected %0d, actual %0d",
                                 $time, due.tokens_left, i_tokens_left);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                policer_verdicts.push_back(police_item(i_func, i_now_ticks, i_packet_bytes));
        end
        o_pending = policer_verdicts.size();
    end

endmodule

FILE: dv/tb_token_bucket_policer_core.sv
`timescale 1ns / 100ps

module tb_token_bucket_policer_core;
    import tbp_pkg::*;

    // selector value the block must ignore, and register slots it must drop
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [TIME_W-1:0]     TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [CFG_DATA_W-1:0] DATA_ONES = {CFG_DATA_W{1'b1}};
    localparam logic [CFG_DATA_W-1:0] RATE_TOP  = 32'd100000000;

    // wait after draining, longer than the pipeline is deep
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1250;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [FUNC_W-1:0]     in_func      = FUNC_REFILL;
    logic [TIME_W-1:0]     in_now       = '0;
    logic [BYTES_W-1:0]    in_bytes     = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  granted;
    logic [TOK_W-1:0]      tokens_left;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_RATE;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int errors;
    int pending;
    int cycle_count = 0;

    // run statistics for the summary
    int n_refill   = 0;
    int n_take     = 0;
    int n_init     = 0;
    int n_unused   = 0;
    int reg_writes = 0;
    int settings   = 0;

    // when set the sender puts beats back to back
    bit steady_input = 1'b0;

    token_bucket_policer_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (in_func),
        .i_now_ticks    (in_now),
        .i_packet_bytes (in_bytes),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_granted      (granted),
        .o_tokens_left  (tokens_left),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    tbp_policer_check i_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_func         (in_func),
        .i_now_ticks    (in_now),
        .i_packet_bytes (in_bytes),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_granted      (granted),
        .i_tokens_left  (tokens_left),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog, generous against the slowest legal run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run hit the %0d cycle limit with %0d results outstanding",
                 CYCLE_LIMIT, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: ready runs, sometimes long, broken by stalls
    initial begin
        int run;
        int stall;
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 8);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // one item beat; valid is left high so the next call can follow with no gap
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [TIME_W-1:0] t,
                             input logic [BYTES_W-1:0] b);
        int gap;
        gap = steady_input ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= f;
        in_now   <= t;
        in_bytes <= b;
        // ready is settled by the falling edge, accept happens at the next rise
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        case (f)
            FUNC_REFILL: n_refill++;
            FUNC_TAKE:   n_take++;
            FUNC_INIT:   n_init++;
            default:     n_unused++;
        endcase
    endtask

    // stop sending and wait until every result is back and the pipe is empty
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    initial begin
        logic [TIME_W-1:0]     clock_now;
        logic [63:0]           wide;
        logic [CFG_DATA_W-1:0] rate_pick;
        logic [CFG_DATA_W-1:0] burst_pick;
        logic [BYTES_W-1:0]    want;
        int                    random_sent;
        int                    phase_len;
        int                    r;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // reset state: rate 0, burst and tokens 65535, no time recorded
        settings++;
        send_item(FUNC_REFILL, '0, '0);           // first refill only records the time
        send_item(FUNC_TAKE, '0, '0);             // zero-byte take always passes
        send_item(FUNC_TAKE, '0, 16'hFFFF);       // empties the bucket
        send_item(FUNC_TAKE, TIME_MAX, 16'd1);    // denied, bucket empty
        send_item(FUNC_UNUSED, TIME_MAX, 16'hFFFF);
        drain_results();

        // 8000 kbps is 1000 bytes per ms; the two spare slots must be dropped
        write_reg(CFG_RATE, 32'd8000);
        write_reg(CFG_BURST, 32'd100000);
        write_reg(CFG_SPARE_LO, DATA_ONES);
        write_reg(CFG_SPARE_HI, 32'd1);
        settings++;
        send_item(FUNC_INIT, TIME_MAX, 16'hFFFF); // tokens back to burst
        send_item(FUNC_TAKE, '0, 16'hFFFF);
        send_item(FUNC_REFILL, 48'd5000, '0);     // first after reinit, time only
        send_item(FUNC_REFILL, 48'd6000, '0);     // exactly 1 ms, slop eats it
        send_item(FUNC_REFILL, 48'd7050, '0);     // 1.05 ms, one ms of tokens
        send_item(FUNC_REFILL, 48'd7000, '0);     // time runs backward
        send_item(FUNC_REFILL, 48'd9000, '0);
        send_item(FUNC_REFILL, TIME_MAX, '0);     // huge interval, fills to burst
        send_item(FUNC_TAKE, '0, 16'd100);
        drain_results();

        // burst lowered under the current tokens: refill must not touch them
        write_reg(CFG_BURST, 32'd50000);
        settings++;
        send_item(FUNC_REFILL, 48'd10, '0);
        send_item(FUNC_REFILL, 48'd100000, '0);
        send_item(FUNC_TAKE, '0, 16'hFFFF);
        send_item(FUNC_REFILL, 48'd200000, '0);   // 99 ms worth, clipped to burst
        drain_results();

        // rate with every bit set, masked to the register width; burst at top
        write_reg(CFG_RATE, DATA_ONES);
        write_reg(CFG_BURST, DATA_ONES);
        settings++;
        send_item(FUNC_INIT, '0, '0);
        send_item(FUNC_TAKE, '0, 16'hFFFF);
        send_item(FUNC_REFILL, 48'd1, '0);
        send_item(FUNC_REFILL, TIME_MAX, '0);
        drain_results();

        // everything at zero
        write_reg(CFG_RATE, '0);
        write_reg(CFG_BURST, '0);
        settings++;
        send_item(FUNC_INIT, '0, '0);
        send_item(FUNC_TAKE, '0, '0);
        send_item(FUNC_TAKE, '0, 16'd1);

        // ---- random part ----
        // each phase: drain, new register values, then mostly well-formed traffic
        // with a clock that moves forward, plus jumps, rewinds and noise
        random_sent = 0;
        clock_now = '0;
        while (random_sent < RANDOM_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 9))
                0:       rate_pick = '0;
                1:       rate_pick = 32'd1;
                2:       rate_pick = 32'd7;
                3:       rate_pick = 32'd8;
                4:       rate_pick = 32'd8000;
                5:       rate_pick = 32'd80000;
                6:       rate_pick = 32'd1000000;
                7:       rate_pick = RATE_TOP;
                8:       rate_pick = DATA_ONES;
                default: rate_pick = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       burst_pick = '0;
                1:       burst_pick = 32'd1;
                2:       burst_pick = 32'd1500;
                3:       burst_pick = 32'd9000;
                4:       burst_pick = 32'd65535;
                5:       burst_pick = 32'd65536;
                6:       burst_pick = 32'd1000000;
                7:       burst_pick = DATA_ONES;
                8:       burst_pick = $urandom_range(0, 200000);
                default: burst_pick = $urandom;
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_RATE, rate_pick);
                write_reg(CFG_BURST, burst_pick);
            end else begin
                write_reg(CFG_BURST, burst_pick);
                write_reg(CFG_RATE, rate_pick);
            end
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
            settings++;
            steady_input = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 160);

            if ($urandom_range(0, 9) < 7) begin
                send_item(FUNC_INIT, clock_now, BYTES_W'($urandom_range(0, 65535)));
                random_sent++;
            end

            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    // refill, mostly a few ms forward
                    case ($urandom_range(0, 19))
                        0:       clock_now = clock_now - $urandom_range(0, 5000);
                        1: begin
                            wide = {$urandom, $urandom};
                            clock_now = wide[TIME_W-1:0];
                        end
                        2:       clock_now = clock_now + 1000 * $urandom_range(0, 4) + 50;
                        3:       clock_now = clock_now + 1049;
                        4, 5, 6: clock_now = clock_now + $urandom_range(0, 200000);
                        default: clock_now = clock_now + $urandom_range(0, 3000);
                    endcase
                    send_item(FUNC_REFILL, clock_now, BYTES_W'($urandom_range(0, 65535)));
                    random_sent++;
                end else if (r < 88) begin
                    case ($urandom_range(0, 9))
                        0:          want = '0;
                        1:          want = 16'hFFFF;
                        2, 3, 4, 5: want = BYTES_W'($urandom_range(0, 2000));
                        default:    want = BYTES_W'($urandom_range(0, 65535));
                    endcase
                    wide = {$urandom, $urandom};
                    send_item(FUNC_TAKE, wide[TIME_W-1:0], want);
                    random_sent++;
                end else if (r < 96) begin
                    wide = {$urandom, $urandom};
                    send_item(FUNC_INIT, wide[TIME_W-1:0], BYTES_W'($urandom_range(0, 65535)));
                    random_sent++;
                end else begin
                    // ignored by the block, not counted
                    wide = {$urandom, $urandom};
                    send_item(FUNC_UNUSED, wide[TIME_W-1:0],
                              BYTES_W'($urandom_range(0, 65535)));
                end
            end
        end

        steady_input = 1'b0;
        drain_results();

        $display("covered %0d refills, %0d takes, %0d reinits, %0d unused selectors",
                 n_refill, n_take, n_init, n_unused);
        $display("across %0d register settings made by %0d register writes",
                 settings, reg_writes);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
